@@ sv/cpd_pkg.sv @@
package cpd_pkg;

    // packet layout
    localparam int HEADER_BYTES  = 26;
    localparam int TRAILER_BYTES = 4;
    localparam int OFS_SOURCE    = 2;
    localparam int OFS_DEST      = 6;
    localparam int OFS_TIME      = 10;
    localparam int OFS_ATOMS     = 18;
    localparam int OFS_SIZE      = 22;
    localparam int MIN_BYTES     = HEADER_BYTES + TRAILER_BYTES;

    // byte counter
    localparam int                 COUNT_W   = 33;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // crc-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration reset
    localparam logic [15:0] VERSION_RESET = 16'd1;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TRUNCATED   = 3'd1;
    localparam logic [2:0] ST_VERSION_ERR = 3'd2;
    localparam logic [2:0] ST_LENGTH_ERR  = 3'd3;
    localparam logic [2:0] ST_CRC_ERR     = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [31:0] source_id;
        logic [31:0] dest_id;
        logic [63:0] sim_time;
        logic [31:0] atom_total;
        logic [31:0] payload_length;
        logic [31:0] carried_crc;
    } t_result;

    // one byte through the crc register, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ sv/cpd_byte_if.sv @@
interface cpd_byte_if;
    import cpd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

@@ sv/cpd_result_if.sv @@
interface cpd_result_if;
    import cpd_pkg::*;

    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [31:0] source_id;
    logic [31:0] dest_id;
    logic [63:0] sim_time;
    logic [31:0] atom_total;
    logic [31:0] payload_length;
    logic [31:0] carried_crc;

    modport source (
        output valid, output kind, output payload_byte, output status,
        output source_id, output dest_id, output sim_time, output atom_total,
        output payload_length, output carried_crc, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input status,
        input source_id, input dest_id, input sim_time, input atom_total,
        input payload_length, input carried_crc, output ready
    );
endinterface

@@ sv/cpd_core.sv @@
module cpd_core
    import cpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [15:0] i_expected_version,
    output logic        o_emit,
    output t_result     o_result
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic [31:0]        r_crc, n_crc;
    logic [31:0]        r_trailer, n_trailer;
    logic [15:0]        r_version, n_version;
    logic [31:0]        r_source, n_source;
    logic [31:0]        r_dest, n_dest;
    logic [63:0]        r_time, n_time;
    logic [31:0]        r_atoms, n_atoms;
    logic [31:0]        r_size, n_size;

    logic [COUNT_W-1:0] w_pay_ofs;
    logic [COUNT_W:0]   w_want_len;
    logic [2:0]         w_status;

    // per-byte state update
    always_comb begin
        n_crc     = (r_count >= COUNT_W'(TRAILER_BYTES)) ? crc_byte(r_crc, r_trailer[7:0])
                                                         : r_crc;
        n_trailer = {i_data_byte, r_trailer[31:8]};
        n_version = (r_count < COUNT_W'(2)) ? {r_version[7:0], i_data_byte} : r_version;
        n_source  = r_source;
        n_dest    = r_dest;
        n_time    = r_time;
        n_atoms   = r_atoms;
        n_size    = r_size;
        for (int k = 0; k < 4; k++) begin
            if (r_count == COUNT_W'(OFS_SOURCE + k)) n_source[8*k +: 8] = i_data_byte;
            if (r_count == COUNT_W'(OFS_DEST + k))   n_dest[8*k +: 8]   = i_data_byte;
            if (r_count == COUNT_W'(OFS_ATOMS + k))  n_atoms[8*k +: 8]  = i_data_byte;
            if (r_count == COUNT_W'(OFS_SIZE + k))   n_size[8*k +: 8]   = i_data_byte;
        end
        for (int k = 0; k < 8; k++) begin
            if (r_count == COUNT_W'(OFS_TIME + k)) n_time[8*k +: 8] = i_data_byte;
        end
        n_count = (r_count != COUNT_MAX) ? r_count + COUNT_W'(1) : r_count;
    end

    // status checks in priority order
    assign w_pay_ofs  = r_count - COUNT_W'(HEADER_BYTES);
    assign w_want_len = (COUNT_W+1)'(MIN_BYTES) + {2'b00, n_size};

    always_comb begin
        if (n_count < COUNT_W'(MIN_BYTES)) begin
            w_status = ST_TRUNCATED;
        end else if (n_version != i_expected_version) begin
            w_status = ST_VERSION_ERR;
        end else if ({1'b0, n_count} != w_want_len) begin
            w_status = ST_LENGTH_ERR;
        end else if (~n_crc != n_trailer) begin
            w_status = ST_CRC_ERR;
        end else begin
            w_status = ST_OK;
        end
    end

    // result item
    always_comb begin
        o_result = '0;
        if (i_last) begin
            o_emit          = 1'b1;
            o_result.kind   = KIND_STATUS;
            o_result.status = w_status;
            if (w_status != ST_TRUNCATED) begin
                o_result.source_id      = n_source;
                o_result.dest_id        = n_dest;
                o_result.sim_time       = n_time;
                o_result.atom_total     = n_atoms;
                o_result.payload_length = n_size;
                o_result.carried_crc    = n_trailer;
            end
        end else begin
            o_emit = (r_count >= COUNT_W'(HEADER_BYTES)) && (w_pay_ofs < {1'b0, n_size});
            o_result.kind         = KIND_PAYLOAD;
            o_result.payload_byte = i_data_byte;
        end
    end

    // packet state, cleared on reset and after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count   <= '0;
            r_crc     <= CRC_INIT;
            r_trailer <= '0;
            r_version <= '0;
            r_source  <= '0;
            r_dest    <= '0;
            r_time    <= '0;
            r_atoms   <= '0;
            r_size    <= '0;
        end else if (i_step) begin
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_trailer <= n_trailer;
            r_version <= n_version;
            r_source  <= n_source;
            r_dest    <= n_dest;
            r_time    <= n_time;
            r_atoms   <= n_atoms;
            r_size    <= n_size;
        end
    end

endmodule

@@ sv/crc_checked_packet_deframer_top.sv @@
// path: an accepted byte passes the input register, then the result register
// throughput: one byte per cycle while the receiver takes results; the
//   byte-wide crc update and header capture sit between the two registers
// reset: synchronous active-low i_rst_n clears the packet state and both
//   valid flags and sets expected_version to 1
module crc_checked_packet_deframer_top
    import cpd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpd_byte_if.sink     i_byte,
    cpd_result_if.source o_result,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_expected_version;

    logic        w_advance;
    logic        w_emit;
    t_result     w_result;

    // input stage moves on when the result slot is free or draining
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || w_advance;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= VERSION_RESET;
        end else if (i_cfg_we) begin
            r_expected_version <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last;
        end
    end

    cpd_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_advance),
        .i_data_byte        (r_in_byte),
        .i_last             (r_in_last),
        .i_expected_version (r_expected_version),
        .o_emit             (w_emit),
        .o_result           (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.kind           = r_out.kind;
    assign o_result.payload_byte   = r_out.payload_byte;
    assign o_result.status         = r_out.status;
    assign o_result.source_id      = r_out.source_id;
    assign o_result.dest_id        = r_out.dest_id;
    assign o_result.sim_time       = r_out.sim_time;
    assign o_result.atom_total     = r_out.atom_total;
    assign o_result.payload_length = r_out.payload_length;
    assign o_result.carried_crc    = r_out.carried_crc;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import cpd_pkg::*;

    // packet flavors for the random stream
    typedef enum int {
        PK_GOOD,
        PK_BAD_VERSION,
        PK_BAD_LENGTH,
        PK_BAD_CRC,
        PK_TRUNCATED,
        PK_CUT_PAYLOAD,
        PK_NOISE
    } t_packet_shape;

    // tracks packet state per byte and holds the results still to come
    class deframe_scoreboard;
        logic [15:0] want_version;
        logic [32:0] seen_bytes;
        logic [31:0] crc_acc;
        logic [15:0] version_acc;
        logic [31:0] source_acc;
        logic [31:0] dest_acc;
        logic [63:0] time_acc;
        logic [31:0] atoms_acc;
        logic [31:0] size_acc;
        logic [31:0] tail_bytes;
        t_result     awaited_results[$];
        int          mismatches;

        function new();
            want_version = VERSION_RESET;
            mismatches   = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            seen_bytes  = '0;
            crc_acc     = CRC_INIT;
            version_acc = '0;
            source_acc  = '0;
            dest_acc    = '0;
            time_acc    = '0;
            atoms_acc   = '0;
            size_acc    = '0;
            tail_bytes  = '0;
        endfunction

        // bit-serial reflected crc-32, one byte
        static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] d);
            logic [31:0] r;
            r = crc;
            for (int n = 0; n < 8; n++) begin
                if (r[0] ^ d[n]) begin
                    r = {1'b0, r[31:1]} ^ CRC_POLY;
                end else begin
                    r = {1'b0, r[31:1]};
                end
            end
            return r;
        endfunction

        // drop a byte into a little-endian word when its offset matches
        static function logic [31:0] merge_le32(logic [31:0] acc, logic [32:0] idx, int ofs,
                                                logic [7:0] d);
            if (idx >= ofs && idx < ofs + 4) begin
                acc = acc | (32'(d) << (8 * (idx - ofs)));
            end
            return acc;
        endfunction

        function void set_version(logic [15:0] v);
            want_version = v;
        endfunction

        // accepted byte transaction: advance the packet and queue any result
        function void note_byte(logic [7:0] d, logic is_last);
            logic [32:0] idx;
            t_result     r;
            logic [2:0]  st;
            idx = seen_bytes;
            r   = '0;

            // the byte leaving the four-byte tail enters the crc
            if (idx >= TRAILER_BYTES) begin
                crc_acc = crc_step(crc_acc, tail_bytes[7:0]);
            end
            tail_bytes = {d, tail_bytes[31:8]};

            // header capture
            if (idx < 2) begin
                version_acc = {version_acc[7:0], d};
            end
            source_acc = merge_le32(source_acc, idx, OFS_SOURCE, d);
            dest_acc   = merge_le32(dest_acc, idx, OFS_DEST, d);
            atoms_acc  = merge_le32(atoms_acc, idx, OFS_ATOMS, d);
            size_acc   = merge_le32(size_acc, idx, OFS_SIZE, d);
            if (idx >= OFS_TIME && idx < OFS_TIME + 8) begin
                time_acc = time_acc | (64'(d) << (8 * (idx - OFS_TIME)));
            end

            if (seen_bytes != COUNT_MAX) begin
                seen_bytes = seen_bytes + 1'b1;
            end

            // payload bytes pass straight through
            if (!is_last) begin
                if (idx >= HEADER_BYTES && (idx - HEADER_BYTES) < size_acc) begin
                    r.kind         = KIND_PAYLOAD;
                    r.payload_byte = d;
                    awaited_results.push_back(r);
                end
                return;
            end

            // final byte: status in priority order
            if (seen_bytes < MIN_BYTES) begin
                st = ST_TRUNCATED;
            end else if (version_acc != want_version) begin
                st = ST_VERSION_ERR;
            end else if (34'(seen_bytes) != 34'(size_acc) + 34'(MIN_BYTES)) begin
                st = ST_LENGTH_ERR;
            end else if (~crc_acc != tail_bytes) begin
                st = ST_CRC_ERR;
            end else begin
                st = ST_OK;
            end

            r.kind   = KIND_STATUS;
            r.status = st;
            if (st != ST_TRUNCATED) begin
                r.source_id      = source_acc;
                r.dest_id        = dest_acc;
                r.sim_time       = time_acc;
                r.atom_total     = atoms_acc;
                r.payload_length = size_acc;
                r.carried_crc    = tail_bytes;
            end
            awaited_results.push_back(r);
            clear_packet();
        endfunction

        function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // accepted result transaction against the oldest expectation
        function void check_result(t_result got);
            t_result want;
            bit      ok;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                         $time, got.kind, got.status);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            ok = 1'b1;
            ok = field_ok("kind", want.kind, got.kind) && ok;
            ok = field_ok("payload_byte", want.payload_byte, got.payload_byte) && ok;
            ok = field_ok("status", want.status, got.status) && ok;
            ok = field_ok("source_id", want.source_id, got.source_id) && ok;
            ok = field_ok("dest_id", want.dest_id, got.dest_id) && ok;
            ok = field_ok("sim_time", want.sim_time, got.sim_time) && ok;
            ok = field_ok("atom_total", want.atom_total, got.atom_total) && ok;
            ok = field_ok("payload_length", want.payload_length, got.payload_length) && ok;
            ok = field_ok("carried_crc", want.carried_crc, got.carried_crc) && ok;
            if (!ok) begin
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    cpd_byte_if   byte_if ();
    cpd_result_if res_if ();

    crc_checked_packet_deframer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_if),
        .o_result    (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    deframe_scoreboard sb;
    logic [7:0]        pkt_bytes[$];
    logic [15:0]       cur_version;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                bytes_sent;
    bit                long_hold_pending;
    t_result           seen_result;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("crc_checked_packet_deframer_top regression: fail");
        $finish;
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
            @(posedge i_clk);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            seen_result.kind           = res_if.kind;
            seen_result.payload_byte   = res_if.payload_byte;
            seen_result.status         = res_if.status;
            seen_result.source_id      = res_if.source_id;
            seen_result.dest_id        = res_if.dest_id;
            seen_result.sim_time       = res_if.sim_time;
            seen_result.atom_total     = res_if.atom_total;
            seen_result.payload_length = res_if.payload_length;
            seen_result.carried_crc    = res_if.carried_crc;
            sb.check_result(seen_result);
        end
    end

    // one byte transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] d, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= d;
        byte_if.last      <= is_last;
        @(posedge i_clk);
        while (byte_if.ready !== 1'b1) @(posedge i_clk);
        sb.note_byte(d, is_last);
        bytes_sent++;
    endtask

    // assemble header, payload and trailer into pkt_bytes
    task automatic build_packet(input logic [15:0] ver, input logic [31:0] src,
                                input logic [31:0] dst, input logic [63:0] tlevel,
                                input logic [31:0] atoms, input logic [31:0] size_field,
                                input int n_pay, input bit bad_crc);
        logic [31:0] crc;
        pkt_bytes.delete();
        pkt_bytes.push_back(ver[15:8]);
        pkt_bytes.push_back(ver[7:0]);
        for (int k = 0; k < 4; k++) pkt_bytes.push_back(src[8*k +: 8]);
        for (int k = 0; k < 4; k++) pkt_bytes.push_back(dst[8*k +: 8]);
        for (int k = 0; k < 8; k++) pkt_bytes.push_back(tlevel[8*k +: 8]);
        for (int k = 0; k < 4; k++) pkt_bytes.push_back(atoms[8*k +: 8]);
        for (int k = 0; k < 4; k++) pkt_bytes.push_back(size_field[8*k +: 8]);
        repeat (n_pay) pkt_bytes.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (pkt_bytes[k]) crc = deframe_scoreboard::crc_step(crc, pkt_bytes[k]);
        crc = ~crc;
        if (bad_crc) begin
            crc = crc ^ (32'd1 << $urandom_range(31));
        end
        for (int k = 0; k < 4; k++) pkt_bytes.push_back(crc[8*k +: 8]);
    endtask

    // send the first n bytes of pkt_bytes, last flag on the final one
    task automatic send_packet(input int n);
        for (int k = 0; k < n; k++) begin
            send_byte(pkt_bytes[k], k == n - 1);
        end
    endtask

    task automatic send_whole_packet();
        send_packet(pkt_bytes.size());
    endtask

    // sender stays quiet until every result is back, then the pipe settles
    task automatic wait_drained();
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_version(input logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_version(v);
        cur_version = v;
        @(posedge i_clk);
    endtask

    task automatic send_random_packet();
        int            pick;
        int            n_pay;
        int            n_send;
        logic [31:0]   size_field;
        logic [15:0]   ver;
        bit            bad_crc;
        t_packet_shape shape;
        pick = $urandom_range(99);
        if (pick < 60) shape = PK_GOOD;
        else if (pick < 68) shape = PK_BAD_VERSION;
        else if (pick < 76) shape = PK_BAD_LENGTH;
        else if (pick < 84) shape = PK_BAD_CRC;
        else if (pick < 90) shape = PK_TRUNCATED;
        else if (pick < 95) shape = PK_CUT_PAYLOAD;
        else shape = PK_NOISE;

        n_pay      = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(20);
        ver        = cur_version;
        bad_crc    = 1'b0;
        size_field = n_pay;
        case (shape)
            PK_BAD_VERSION: ver = cur_version ^ 16'($urandom_range(1, 16'hFFFF));
            PK_BAD_LENGTH:  size_field = size_field ^ (32'd1 << $urandom_range(31));
            PK_BAD_CRC:     bad_crc = 1'b1;
            PK_CUT_PAYLOAD: begin
                if (n_pay == 0) n_pay = 1;
                size_field = n_pay;
            end
            default: ;
        endcase
        build_packet(ver, $urandom, $urandom, {$urandom, $urandom}, $urandom, size_field,
                     n_pay, bad_crc);
        n_send = pkt_bytes.size();
        case (shape)
            PK_TRUNCATED:   n_send = $urandom_range(1, MIN_BYTES - 1);
            PK_CUT_PAYLOAD: n_send = HEADER_BYTES + $urandom_range(1, n_pay);
            PK_NOISE: begin
                pkt_bytes.delete();
                repeat ($urandom_range(1, 60)) pkt_bytes.push_back(8'($urandom));
                n_send = pkt_bytes.size();
            end
            default: ;
        endcase
        send_packet(n_send);
    endtask

    // one random phase at a given version and idle mix
    task automatic run_phase(input logic [15:0] ver, input int tx_pct, input int rx_pct,
                             input int n_bytes, input bit long_hold);
        int target;
        byte_if.valid <= 1'b0;
        wait_drained();
        write_version(ver);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (long_hold) begin
            long_hold_pending = 1'b1;
        end
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) send_random_packet();
    endtask

    // directed packets at the reset version
    task automatic run_directed();
        // lone all-ones byte: truncated
        build_packet(16'hFFFF, '1, '1, '1, '1, '1, 0, 1'b0);
        send_packet(1);
        // one byte short of a minimal packet
        build_packet(16'd1, '0, '0, '0, '0, 32'd0, 0, 1'b0);
        send_packet(MIN_BYTES - 1);
        // minimal good packet, zero header fields
        send_whole_packet();
        // all-ones header fields, short payload
        build_packet(16'd1, '1, '1, '1, '1, 32'd4, 4, 1'b0);
        send_whole_packet();
        // version mismatch at both extremes
        build_packet(16'hFFFF, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd2, 2,
                     1'b0);
        send_whole_packet();
        build_packet(16'h0000, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd0, 0,
                     1'b0);
        send_whole_packet();
        // declared size beyond the bytes sent
        build_packet(16'd1, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd5, 3, 1'b0);
        send_whole_packet();
        // last flag inside the payload
        build_packet(16'd1, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd10, 10,
                     1'b0);
        send_packet(HEADER_BYTES + 6);
        // extra bytes past the declared payload
        build_packet(16'd1, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd2, 6, 1'b0);
        send_whole_packet();
        // largest declared size
        build_packet(16'd1, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'hFFFF_FFFF,
                     3, 1'b0);
        send_whole_packet();
        // corrupted trailer
        build_packet(16'd1, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd8, 8, 1'b1);
        send_whole_packet();
        // version wins over length and crc
        build_packet(16'd2, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd7, 1, 1'b1);
        send_whole_packet();
        // length wins over crc
        build_packet(16'd1, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd9, 3, 1'b1);
        send_whole_packet();
        // good packet with a longer payload
        build_packet(16'd1, $urandom, $urandom, {$urandom, $urandom}, $urandom, 32'd20, 20,
                     1'b0);
        send_whole_packet();
    endtask

    // main sequence
    initial begin
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'd0;
        byte_if.last      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 16'd0;
        i_rst_n           = 1'b0;
        tx_idle_pct       = 20;
        rx_idle_pct       = 20;
        bytes_sent        = 0;
        long_hold_pending = 1'b0;
        cur_version       = VERSION_RESET;
        sb                = new();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(16'hFFFF, 37, 64, 480, 1'b0);
        run_phase(16'h0000, 64, 37, 480, 1'b0);
        run_phase(16'($urandom), 0, 0, 480, 1'b1);

        byte_if.valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("crc_checked_packet_deframer_top regression: pass");
        end else begin
            $display("crc_checked_packet_deframer_top regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/cpd_pkg.sv
sv/cpd_byte_if.sv
sv/cpd_result_if.sv
sv/cpd_core.sv
sv/crc_checked_packet_deframer_top.sv
bench/tb.sv
